FILE: rtl/tedf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedf_pkg
// Shared types and constants of the timed event dedupe filter.
// ----------------------------------------------------------------------------
package tedf_pkg;

   localparam int HISTORY_DEPTH = 8;
   localparam int ADDRESS_BITS  = 32;
   localparam int TIME_BITS     = 48;
   localparam int WINDOW_BITS   = 16;
   localparam int KIND_BITS     = 3;
   localparam int IDX_BITS      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd2000;

   // event kind codes
   localparam logic [KIND_BITS-1:0] KIND_NONE           = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_UNLOCK_STARTED = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_UNLOCK_ENDED   = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_LIGHT_ON       = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_LIGHT_RELEASED = 3'd4;

   localparam logic MODE_CHECK    = 1'b0;
   localparam logic MODE_REMEMBER = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [KIND_BITS-1:0]    event_kind;
      logic                    address_present;
      logic [ADDRESS_BITS-1:0] address_key;
      logic [TIME_BITS-1:0]    now_ms;
   } req_type;

   typedef struct packed {
      logic is_duplicate;
      logic stored;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_idx;
      logic inc_idx;
      logic store;
      logic set_result;
      logic res_dup;
      logic res_stored;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eligible;
      logic remember_only;
      logic match;
      logic last_idx;
   } status_type;

endpackage

FILE: rtl/tedf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedf_dpath
// History ring, scan comparator, window register and result register.
// ----------------------------------------------------------------------------
module tedf_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  tedf_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [tedf_pkg::WINDOW_BITS-1:0]    csr_wdata,
   input  tedf_pkg::cmd_type                   cmd,
   output tedf_pkg::status_type                status,
   output tedf_pkg::rsp_type                   rsp_data
);

   tedf_pkg::req_type                       item_ff;
   logic [tedf_pkg::WINDOW_BITS-1:0]        window_ff;
   logic [tedf_pkg::IDX_BITS-1:0]           idx_ff, idx_in;
   logic [tedf_pkg::IDX_BITS-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [tedf_pkg::TIME_BITS-1:0]          time_ff [tedf_pkg::HISTORY_DEPTH];
   logic [tedf_pkg::KIND_BITS-1:0]          kind_ff [tedf_pkg::HISTORY_DEPTH];
   logic [tedf_pkg::ADDRESS_BITS-1:0]       addr_ff [tedf_pkg::HISTORY_DEPTH];
   tedf_pkg::rsp_type                       rsp_ff;

   logic [tedf_pkg::TIME_BITS-1:0]          sel_time;
   logic [tedf_pkg::TIME_BITS-1:0]          age;
   logic                                    time_ok;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= tedf_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         window_ff <= csr_wdata;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (cmd.store) begin
         if (wr_ptr_ff == tedf_pkg::IDX_BITS'(tedf_pkg::HISTORY_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         wr_ptr_ff <= '0;
      end else begin
         idx_ff    <= idx_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // zero time marks an empty entry, so only the time field is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tedf_pkg::HISTORY_DEPTH; i++) begin
            time_ff[i] <= '0;
         end
      end else if (cmd.store) begin
         time_ff[wr_ptr_ff] <= item_ff.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         kind_ff[wr_ptr_ff] <= item_ff.event_kind;
         addr_ff[wr_ptr_ff] <= item_ff.address_key;
      end
   end

   assign sel_time = time_ff[idx_ff];
   assign age      = item_ff.now_ms - sel_time;
   assign time_ok  = (sel_time != '0) && (item_ff.now_ms >= sel_time) &&
                     (age < tedf_pkg::TIME_BITS'(window_ff));

   assign status.match         = time_ok && (kind_ff[idx_ff] == item_ff.event_kind) &&
                                 (addr_ff[idx_ff] == item_ff.address_key);
   assign status.last_idx      = (idx_ff == tedf_pkg::IDX_BITS'(tedf_pkg::HISTORY_DEPTH - 1));
   assign status.remember_only = (item_ff.mode == tedf_pkg::MODE_REMEMBER);
   assign status.eligible      = item_ff.address_present &&
                                 (item_ff.event_kind >= tedf_pkg::KIND_UNLOCK_STARTED) &&
                                 (item_ff.event_kind <= tedf_pkg::KIND_LIGHT_RELEASED);

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         rsp_ff.is_duplicate <= cmd.res_dup;
         rsp_ff.stored       <= cmd.res_stored;
      end
   end

   assign rsp_data = rsp_ff;

   a_dup_needs_match: assert property (@(posedge clock) disable iff (reset)
      (cmd.set_result && cmd.res_dup) |-> status.match)
      else $error("duplicate reported without a matching entry");

   a_store_moves_ptr: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> (wr_ptr_ff == $past(wr_ptr_in)))
      else $error("write pointer did not advance on store");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.set_result |-> !(cmd.res_dup && cmd.res_stored))
      else $error("word both duplicate and stored");

endmodule

FILE: rtl/tedf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedf_ctrl
// Sequencer: decide, scan history one entry a cycle, store, emit result.
// ----------------------------------------------------------------------------
module tedf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  tedf_pkg::status_type  status,
   output tedf_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECIDE = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_STORE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.eligible) begin
               cmd.set_result = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.remember_only) begin
               state_in = ST_STORE;
            end else begin
               cmd.clear_idx = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match) begin
               cmd.set_result = 1'b1;
               cmd.res_dup    = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.last_idx) begin
               state_in = ST_STORE;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         ST_STORE: begin
            cmd.store      = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_stored = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.set_result;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_result_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in work");

endmodule

FILE: rtl/timed_event_dedupe_filter.sv
`timescale 1ns / 1ps
// An accepted word is loaded and decided: an ignored word sets its result in the decide
// state, a remember-only word is stored, and a check word scans the history from entry 0,
// one history entry a cycle, until a duplicate hit or the last of the 8 entries and is
// then stored. Busy holds off the next word until the sequencer is idle; the next word may
// start while the result strobe is high. The receiver cannot stall. Synchronous reset
// clears the history times, write pointer and sequencer and sets the window to 2000 ms.
// ----------------------------------------------------------------------------
// timed_event_dedupe_filter
// Suppresses repeated events of the same kind and address within a time window.
// ----------------------------------------------------------------------------
module timed_event_dedupe_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  tedf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output tedf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tedf_pkg::WINDOW_BITS-1:0]  csr_wdata
);

   tedf_pkg::cmd_type    cmd;
   tedf_pkg::status_type status;

   // window writes must come only while idle; the block does not enforce it, so always ready
   assign csr_ready = 1'b1;

   tedf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   tedf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/timed_event_dedupe_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_dedupe_filter_tb
// Drives directed and random event words into the dedupe filter and checks
// every result word against an in-bench model of the history ring. The window
// register is rewritten between phases while the filter is idle.
// ----------------------------------------------------------------------------
module timed_event_dedupe_filter_tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_WORDS = 200;
   localparam int KIND_CODES  = 2 ** tedf_pkg::KIND_BITS;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             start     = 1'b0;
   logic                             busy;
   tedf_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   tedf_pkg::rsp_type                rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tedf_pkg::WINDOW_BITS-1:0] csr_wdata = '0;

   timed_event_dedupe_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // history ring as the filter should hold it
   logic [tedf_pkg::TIME_BITS-1:0]    hist_time [tedf_pkg::HISTORY_DEPTH];
   logic [tedf_pkg::KIND_BITS-1:0]    hist_kind [tedf_pkg::HISTORY_DEPTH];
   logic [tedf_pkg::ADDRESS_BITS-1:0] hist_addr [tedf_pkg::HISTORY_DEPTH];
   logic [tedf_pkg::IDX_BITS-1:0]     hist_wr;
   logic [tedf_pkg::WINDOW_BITS-1:0]  hist_window_ms;

   tedf_pkg::req_type event_q [$];
   tedf_pkg::rsp_type verdict_q [$];

   logic              sending      = 1'b0;
   logic              sender_idles = 1'b1;
   int                gap_left     = 0;
   logic              moved;
   tedf_pkg::rsp_type want;
   int                idle_cycles  = 0;
   int                error_count  = 0;
   int                words_sent   = 0;
   int                results_seen = 0;
   int                dup_count    = 0;
   int                stored_count = 0;
   int                drop_count   = 0;
   int                windows_set  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // scan the ring for check words, then store a recognized addressed word unless it hit
   function automatic tedf_pkg::rsp_type dedupe_verdict(tedf_pkg::req_type ev);
      tedf_pkg::rsp_type v;
      v = '0;
      if (ev.address_present && ev.event_kind >= tedf_pkg::KIND_UNLOCK_STARTED &&
          ev.event_kind <= tedf_pkg::KIND_LIGHT_RELEASED) begin
         if (ev.mode == tedf_pkg::MODE_CHECK) begin
            for (int i = 0; i < tedf_pkg::HISTORY_DEPTH; i++) begin
               if (hist_time[i] != '0 && ev.now_ms >= hist_time[i] &&
                   ev.now_ms - hist_time[i] < tedf_pkg::TIME_BITS'(hist_window_ms) &&
                   hist_kind[i] == ev.event_kind && hist_addr[i] == ev.address_key)
                  v.is_duplicate = 1'b1;
            end
         end
         if (!v.is_duplicate) begin
            hist_time[hist_wr] = ev.now_ms;
            hist_kind[hist_wr] = ev.event_kind;
            hist_addr[hist_wr] = ev.address_key;
            hist_wr = (hist_wr == tedf_pkg::IDX_BITS'(tedf_pkg::HISTORY_DEPTH - 1)) ?
                      '0 : hist_wr + 1'b1;
            v.stored = 1'b1;
         end
      end
      return v;
   endfunction

   function automatic int word_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic flag_error(string msg);
      if (error_count < 10) $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic add_event(logic m, logic [tedf_pkg::KIND_BITS-1:0] k, logic p,
                            logic [tedf_pkg::ADDRESS_BITS-1:0] a,
                            logic [tedf_pkg::TIME_BITS-1:0] t);
      tedf_pkg::req_type ev;
      ev.mode            = m;
      ev.event_kind      = k;
      ev.address_present = p;
      ev.address_key     = a;
      ev.now_ms          = t;
      event_q.push_back(ev);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (event_q.size() != 0 || start || verdict_q.size() != 0);
   endtask

   task automatic set_window(logic [tedf_pkg::WINDOW_BITS-1:0] w);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= w;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      windows_set++;
   endtask

   // mostly recognized events on a moving clock over a few addresses, plus noise
   task automatic random_events(int count, int win);
      int                                made;
      int                                r;
      int                                r2;
      logic [tedf_pkg::TIME_BITS-1:0]    t;
      logic [tedf_pkg::TIME_BITS-1:0]    stamp;
      logic [tedf_pkg::TIME_BITS-1:0]    step;
      logic [tedf_pkg::ADDRESS_BITS-1:0] pool [4];
      logic [tedf_pkg::ADDRESS_BITS-1:0] addr;
      logic [tedf_pkg::KIND_BITS-1:0]    kind;
      logic                              present;
      made    = 0;
      t       = {16'($urandom_range(0, 65535)), 32'($urandom)};
      pool[0] = $urandom;
      pool[1] = pool[0] ^ (32'd1 << $urandom_range(0, 31));
      pool[2] = $urandom;
      pool[3] = ~pool[0];
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            kind    = 3'($urandom);
            present = (kind >= tedf_pkg::KIND_UNLOCK_STARTED &&
                       kind <= tedf_pkg::KIND_LIGHT_RELEASED) ? 1'b0 : 1'($urandom);
            add_event(1'($urandom), kind, present, 32'($urandom),
                      {16'($urandom), 32'($urandom)});
            made++;
         end else begin
            r2 = $urandom_range(0, 9);
            if (r2 < 6) step = tedf_pkg::TIME_BITS'($urandom_range(0, win / 3));
            else if (r2 < 9) step = tedf_pkg::TIME_BITS'($urandom_range(win / 2,
                                                                         win + win / 2));
            else step = tedf_pkg::TIME_BITS'($urandom);
            t     = t + step;
            stamp = t;
            if (r < 18) stamp = t - tedf_pkg::TIME_BITS'($urandom_range(0, win));
            else if (r < 21) stamp = '0;
            addr = (r >= 21 && r < 26) ? 32'($urandom) : pool[2'($urandom_range(0, 3))];
            add_event(($urandom_range(0, 9) == 0) ? tedf_pkg::MODE_REMEMBER :
                      tedf_pkg::MODE_CHECK,
                      3'($urandom_range(1, 4)), 1'b1, addr, stamp);
            made++;
         end
      end
   endtask

   // driver: start stays up until the word is taken
   always @(posedge clock) begin
      if (reset) begin
         sending  = 1'b0;
         gap_left = 0;
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            sending  = 1'b0;
            gap_left = sender_idles ? word_gap() : 0;
         end
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (event_q.size() > 0) begin
               req_data <= event_q.pop_front();
               sending = 1'b1;
            end
         end
         start <= sending;
      end
   end

   // monitor: check result words, predict accepted words, track the window
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved = 1'b1;
            if (verdict_q.size() == 0) begin
               flag_error($sformatf("result word %0d with nothing pending: dup %0b stored %0b",
                                    results_seen, rsp_data.is_duplicate, rsp_data.stored));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.is_duplicate !== want.is_duplicate ||
                   rsp_data.stored !== want.stored)
                  flag_error($sformatf(
                     "word %0d: expected dup %0b stored %0b, got dup %0b stored %0b",
                     results_seen, want.is_duplicate, want.stored,
                     rsp_data.is_duplicate, rsp_data.stored));
               if (want.is_duplicate) dup_count++;
               else if (want.stored) stored_count++;
               else drop_count++;
            end
            results_seen++;
         end
         if (start && !busy) begin
            moved = 1'b1;
            verdict_q.push_back(dedupe_verdict(req_data));
            words_sent++;
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            hist_window_ms = csr_wdata;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("[%0t] no progress for %0d cycles, %0d results outstanding",
               $time, idle_cycles, verdict_q.size());
      $display("timed_event_dedupe_filter verification failed");
      $finish;
   end

   initial begin
      logic [tedf_pkg::WINDOW_BITS-1:0]  plan [7];
      logic [tedf_pkg::ADDRESS_BITS-1:0] dev;
      for (int i = 0; i < tedf_pkg::HISTORY_DEPTH; i++) begin
         hist_time[i] = '0;
         hist_kind[i] = '0;
         hist_addr[i] = '0;
      end
      hist_wr        = '0;
      hist_window_ms = tedf_pkg::WINDOW_RESET;
      dev            = 32'h0000_00A5;
      plan = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd300,
               16'($urandom_range(2, 999)), tedf_pkg::WINDOW_RESET, 16'd0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset window of 2000 ms
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_STARTED, 1'b1, dev, 48'd1000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_STARTED, 1'b1, dev, 48'd1500);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_STARTED, 1'b1, dev, 48'd2999);
      // age equal to the window is no longer a duplicate
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_STARTED, 1'b1, dev, 48'd3000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_ENDED, 1'b1, dev, 48'd3000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_NONE, 1'b1, dev, 48'd3000);
      for (int k = int'(tedf_pkg::KIND_LIGHT_RELEASED) + 1; k < KIND_CODES; k++)
         add_event(tedf_pkg::MODE_CHECK, 3'(k), 1'b1, dev, 48'd3000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_STARTED, 1'b0, dev, 48'd3100);
      add_event(tedf_pkg::MODE_REMEMBER, tedf_pkg::KIND_LIGHT_ON, 1'b1, '1, 48'd3100);
      add_event(tedf_pkg::MODE_REMEMBER, tedf_pkg::KIND_LIGHT_ON, 1'b1, '1, 48'd3100);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_ON, 1'b1, '1, 48'd3100);
      add_event(tedf_pkg::MODE_REMEMBER, tedf_pkg::KIND_NONE, 1'b1, '1, 48'd3100);
      // every matching entry lies after now
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_STARTED, 1'b1, dev, 48'd900);
      // zero time gets stored but reads back as empty
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_RELEASED, 1'b1, '0, '0);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_RELEASED, 1'b1, '0, '0);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_RELEASED, 1'b1, '0, 48'd5);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_ON, 1'b1, 32'h5A5A_C3C3, '1);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_ON, 1'b1, 32'h5A5A_C3C3, '1);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_LIGHT_ON, 1'b1, 32'h5A5A_C3C2, '1);

      wait_idle();
      set_window('0);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_ENDED, 1'b1, dev, 48'd4000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_ENDED, 1'b1, dev, 48'd4000);
      wait_idle();
      set_window(16'd1);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_ENDED, 1'b1, dev, 48'd5000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_ENDED, 1'b1, dev, 48'd5000);
      add_event(tedf_pkg::MODE_CHECK, tedf_pkg::KIND_UNLOCK_ENDED, 1'b1, dev, 48'd5001);

      for (int p = 0; p < 7; p++) begin
         wait_idle();
         set_window(plan[p]);
         sender_idles = (p % 3 != 1);
         if (p == 2) begin
            // hold the sender until the filter has drained
            random_events(PHASE_WORDS / 2, int'(plan[p]));
            wait_idle();
            random_events(PHASE_WORDS / 2, int'(plan[p]));
         end else begin
            random_events(PHASE_WORDS, int'(plan[p]));
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d event words over %0d window settings, 0 and 1 and 65535 included",
               words_sent, windows_set + 1);
      $display("expected %0d duplicates, %0d stored, %0d dropped as unrecognized or unaddressed",
               dup_count, stored_count, drop_count);
      if (error_count == 0)
         $display("timed_event_dedupe_filter verification clean");
      else
         $display("timed_event_dedupe_filter verification failed");
      $finish;
   end

endmodule
